>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks that sleep while reset is asserted
`define MLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checks that also cover the reset cycles
`define MLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/mlcd_pkg.sv
`default_nettype none
package mlcd_pkg;

  typedef enum logic [1:0] {
    OP_SET_PIXEL   = 2'd0,
    OP_START_FRAME = 2'd1,
    OP_FLUSH_ROW   = 2'd2,
    OP_END_FRAME   = 2'd3
  } op_t;

  // widths set by the largest supported panel (256 rows, 512 columns)
  localparam int ROW_W   = 8;
  localparam int CWORD_W = 4;

  localparam logic [7:0]  CMD_WRITE_BYTE = 8'h01;
  localparam logic [7:0]  CMD_TRAIL_BYTE = 8'h00;
  localparam logic [31:0] WORD_ONES      = 32'hffff_ffff;

  typedef struct packed {
    op_t                op;
    logic [ROW_W-1:0]   row;
    logic [CWORD_W-1:0] cword;
    logic [4:0]         bit_idx;
    logic               pixel_on;
  } cmd_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } out_t;

endpackage
`default_nettype wire

>>> design/mlcd_fifo.sv
`default_nettype none
module mlcd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/mlcd_front.sv
`default_nettype none
module mlcd_front
  import mlcd_pkg::*;
#(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation,
  input  wire logic [15:0] x_coord,
  input  wire logic [15:0] y_coord,
  input  wire logic        pixel_on,
  input  wire logic        back_ready,
  input  wire logic        cmd_pop,
  output cmd_t             cmd,
  output logic             cmd_valid
);

  localparam logic [16:0] ROWS_L = 17'(ROWS);
  localparam logic [16:0] COLS_L = 17'(COLS);

  cmd_t                 cmd_in;
  logic                 x_ok, y_ok, keep, q_full, q_empty;
  logic [$bits(cmd_t)-1:0] q_out;

  assign x_ok = ({1'b0, x_coord} < COLS_L);
  assign y_ok = ({1'b0, y_coord} < ROWS_L);

  // out-of-range pixel writes and row flushes do nothing, so they never enter the queue
  always_comb begin
    case (op_t'(operation))
      OP_SET_PIXEL: keep = x_ok && y_ok;
      OP_FLUSH_ROW: keep = y_ok;
      default:      keep = 1'b1;
    endcase
  end

  assign cmd_in.op       = op_t'(operation);
  assign cmd_in.row      = y_coord[ROW_W-1:0];
  assign cmd_in.cword    = x_coord[CWORD_W+4:5];
  assign cmd_in.bit_idx  = x_coord[4:0];
  assign cmd_in.pixel_on = pixel_on;

  assign full = q_full || !back_ready;

  mlcd_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push && !full && keep),
    .wr_data (cmd_in),
    .full    (q_full),
    .pop     (cmd_pop),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  assign cmd       = cmd_t'(q_out);
  assign cmd_valid = !q_empty;

endmodule
`default_nettype wire

>>> design/mlcd_back.sv
`default_nettype none
module mlcd_back
  import mlcd_pkg::*;
#(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  input  wire logic cmd_valid,
  output logic      cmd_pop,
  output logic      ready,
  output out_t      out_item,
  output logic      out_push,
  input  wire logic out_full
);

  localparam int WPR   = COLS / 32;
  localparam int WORDS = ROWS * WPR;
  localparam int AW    = $clog2(WORDS);
  localparam int KW    = $clog2(WPR + 1);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_PIX_RD   = 11'b000_0000_0100,
    ST_PIX_WR   = 11'b000_0000_1000,
    ST_CMP_RD   = 11'b000_0001_0000,
    ST_CMP_CHK  = 11'b000_0010_0000,
    ST_HEAD     = 11'b000_0100_0000,
    ST_DAT_RD   = 11'b000_1000_0000,
    ST_DAT_EMIT = 11'b001_0000_0000,
    ST_TRAIL    = 11'b010_0000_0000,
    ST_WRCMD    = 11'b100_0000_0000
  } state_t;

  state_t         state_r, state_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [KW-1:0]  off_r, off_nxt;
  logic [1:0]     bsel_r, bsel_nxt;
  logic           diff_r, diff_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;

  logic [31:0]    frm_mem [WORDS];
  logic [31:0]    shd_mem [WORDS];
  logic [31:0]    frm_q_r, shd_q_r;
  logic           frm_re, shd_re, frm_we, shd_we;
  logic [AW-1:0]  addr, frm_wa, shd_wa;
  logic [31:0]    frm_wd, shd_wd, bit_mask;
  logic           last_word;

  assign addr      = base_r + AW'(off_r);
  assign bit_mask  = 32'd1 << cmd_r.bit_idx;
  assign last_word = (off_r == KW'(WPR - 1));
  assign ready     = (state_r != ST_CLEAR);

  always_ff @(posedge clk) begin
    if (frm_we) begin
      frm_mem[frm_wa] <= frm_wd;
    end
    if (frm_re) begin
      frm_q_r <= frm_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (shd_we) begin
      shd_mem[shd_wa] <= shd_wd;
    end
    if (shd_re) begin
      shd_q_r <= shd_mem[addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    base_nxt  = base_r;
    off_nxt   = off_r;
    bsel_nxt  = bsel_r;
    diff_nxt  = diff_r;
    clr_nxt   = clr_r;
    cmd_pop   = 1'b0;
    frm_re    = 1'b0;
    shd_re    = 1'b0;
    frm_we    = 1'b0;
    shd_we    = 1'b0;
    frm_wa    = addr;
    shd_wa    = addr;
    frm_wd    = WORD_ONES;
    shd_wd    = frm_q_r;
    out_push  = 1'b0;
    out_item  = '{stream_byte: CMD_TRAIL_BYTE, last_byte: 1'b1};

    unique case (state_r)
      ST_CLEAR: begin
        frm_we  = 1'b1;
        shd_we  = 1'b1;
        frm_wa  = clr_r;
        shd_wa  = clr_r;
        shd_wd  = WORD_ONES;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd;
          base_nxt = AW'(cmd.row * WPR);
          diff_nxt = 1'b0;
          unique case (cmd.op)
            OP_SET_PIXEL: begin
              off_nxt   = KW'(cmd.cword);
              state_nxt = ST_PIX_RD;
            end
            OP_START_FRAME: state_nxt = ST_WRCMD;
            OP_FLUSH_ROW: begin
              off_nxt   = '0;
              state_nxt = ST_CMP_RD;
            end
            OP_END_FRAME:   state_nxt = ST_TRAIL;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: begin
        frm_re    = 1'b1;
        state_nxt = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        frm_we    = 1'b1;
        frm_wd    = cmd_r.pixel_on ? (frm_q_r | bit_mask) : (frm_q_r & ~bit_mask);
        state_nxt = ST_IDLE;
      end
      ST_CMP_RD: begin
        frm_re    = 1'b1;
        shd_re    = 1'b1;
        state_nxt = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        diff_nxt = diff_r || (frm_q_r != shd_q_r);
        if (last_word) begin
          off_nxt   = '0;
          state_nxt = diff_nxt ? ST_HEAD : ST_IDLE;
        end else begin
          off_nxt   = off_r + 1'b1;
          state_nxt = ST_CMP_RD;
        end
      end
      ST_HEAD: begin
        out_item = '{stream_byte: cmd_r.row, last_byte: 1'b0};
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = ST_DAT_RD;
        end
      end
      ST_DAT_RD: begin
        frm_re    = 1'b1;
        bsel_nxt  = '0;
        state_nxt = ST_DAT_EMIT;
      end
      ST_DAT_EMIT: begin
        // copy the word into the shadow while its bytes go out
        shd_we   = 1'b1;
        out_item = '{stream_byte: frm_q_r[bsel_r*8 +: 8], last_byte: 1'b0};
        if (!out_full) begin
          out_push = 1'b1;
          bsel_nxt = bsel_r + 1'b1;
          if (bsel_r == 2'd3) begin
            if (last_word) begin
              state_nxt = ST_TRAIL;
            end else begin
              off_nxt   = off_r + 1'b1;
              state_nxt = ST_DAT_RD;
            end
          end
        end
      end
      ST_TRAIL: begin
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_WRCMD: begin
        out_item = '{stream_byte: CMD_WRITE_BYTE, last_byte: 1'b1};
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    base_r <= base_nxt;
    off_r  <= off_nxt;
    bsel_r <= bsel_nxt;
    diff_r <= diff_nxt;
  end

endmodule
`default_nettype wire

>>> design/memory_lcd_dirty_row_framebuffer_unit.sv
// a single-byte result (start or end frame) goes through the command queue and the result queue
// set pixel occupies the sequencer for a queue pop, a frame read and a frame write
// flush row compares the row word by word with the shadow and, when any word differs, sends
// the row number, its bytes and a trailer, paced by the single read port of the frame memory
// reset: synchronous, then a clearing pass over all ROWS*COLS/32 words (512 by default)
// sets both stores to all ones while full stays high
`default_nettype none
module memory_lcd_dirty_row_framebuffer_unit
  import mlcd_pkg::*;
#(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_x_coord,
  input  wire logic [15:0] in_y_coord,
  input  wire logic        in_pixel_on,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_stream_byte,
  output logic             out_last_byte
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop, back_ready;
  out_t out_item, out_head;
  logic out_push, out_full;
  logic [$bits(out_t)-1:0] out_q;

  mlcd_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .operation  (in_operation),
    .x_coord    (in_x_coord),
    .y_coord    (in_y_coord),
    .pixel_on   (in_pixel_on),
    .back_ready (back_ready),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid)
  );

  mlcd_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .ready     (back_ready),
    .out_item  (out_item),
    .out_push  (out_push),
    .out_full  (out_full)
  );

  mlcd_fifo #(
    .W     ($bits(out_t)),
    .DEPTH (4)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (out_item),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_q),
    .empty   (out_empty)
  );

  assign out_head        = out_t'(out_q);
  assign out_stream_byte = out_head.stream_byte;
  assign out_last_byte   = out_head.last_byte;

endmodule
`default_nettype wire

>>> design/mlcd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mlcd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [7:0]  out_stream_byte,
  input wire logic        out_last_byte
);

  // reset empties the result queue
  `MLCD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty, "result queue not empty after reset")

  // the clearing pass after reset holds off new transactions
  `MLCD_ASSERT_ALWAYS(a_reset_full, !rst_n |=> in_full, "input open during clearing pass")

  // a closing byte is always the write command or the trailer
  `MLCD_ASSERT(a_last_code,
    !out_empty && out_last_byte |-> out_stream_byte == 8'h00 || out_stream_byte == 8'h01,
    "last byte is neither command nor trailer")

  `MLCD_ASSERT(a_out_hold,
    !out_empty && !out_pop |=> !out_empty && $stable(out_stream_byte) && $stable(out_last_byte),
    "waiting result changed")

endmodule

bind memory_lcd_dirty_row_framebuffer_unit mlcd_checker u_mlcd_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlcd_pkg::*;

  localparam int PANEL_ROWS    = 128;
  localparam int PANEL_COLS    = 128;
  localparam int WORDS_PER_ROW = PANEL_COLS / 32;
  localparam int BYTES_PER_ROW = PANEL_COLS / 8;
  localparam int STORE_WORDS   = PANEL_ROWS * WORDS_PER_ROW;
  localparam int RANDOM_ITEMS  = 180;
  localparam int N_DIRECTED    = 23;
  localparam int DRAIN_CYCLES  = 60;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_operation;
  logic [15:0] in_x_coord;
  logic [15:0] in_y_coord;
  logic        in_pixel_on;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_stream_byte;
  logic        out_last_byte;

  memory_lcd_dirty_row_framebuffer_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_pixel_on     (in_pixel_on),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_stream_byte (out_stream_byte),
    .out_last_byte   (out_last_byte)
  );

  typedef struct {
    op_t         op;
    logic [15:0] x;
    logic [15:0] y;
    logic        on;
    bit          typed;
    int          typed_n;
    logic [7:0]  typed_byte;
    logic        typed_last;
  } stim_row_t;

  // mirror of the panel state: what is drawn and what the panel holds
  logic [31:0] frame_words  [STORE_WORDS];
  logic [31:0] shadow_words [STORE_WORDS];
  out_t        expected_bytes [$];
  stim_row_t   directed_rows [N_DIRECTED];

  int fail_count = 0;
  int items_sent = 0;
  bit send_burst = 1'b0;
  bit pop_burst  = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < STORE_WORDS; i++) begin
      frame_words[i]  = WORD_ONES;
      shadow_words[i] = WORD_ONES;
    end
  end

  function automatic void push_byte(logic [7:0] value, logic last);
    out_t entry;
    entry.stream_byte = value;
    entry.last_byte   = last;
    expected_bytes.push_back(entry);
  endfunction

  function automatic void predict_panel_bytes(op_t op, logic [15:0] x, logic [15:0] y,
                                              logic on);
    int         base;
    int         idx;
    bit         differs;
    logic [31:0] w;
    case (op)
      OP_SET_PIXEL: begin
        if (x < PANEL_COLS && y < PANEL_ROWS) begin
          idx = int'(y) * WORDS_PER_ROW + int'(x[15:5]);
          frame_words[idx][x[4:0]] = on;
        end
      end
      OP_START_FRAME: push_byte(CMD_WRITE_BYTE, 1'b1);
      OP_FLUSH_ROW: begin
        if (y < PANEL_ROWS) begin
          base    = int'(y) * WORDS_PER_ROW;
          differs = 1'b0;
          for (int k = 0; k < WORDS_PER_ROW; k++)
            if (frame_words[base + k] != shadow_words[base + k]) differs = 1'b1;
          if (differs) begin
            push_byte(y[7:0], 1'b0);
            for (int b = 0; b < BYTES_PER_ROW; b++) begin
              w = frame_words[base + b / 4];
              push_byte(w[8 * (b % 4) +: 8], 1'b0);
            end
            push_byte(CMD_TRAIL_BYTE, 1'b1);
            for (int k = 0; k < WORDS_PER_ROW; k++)
              shadow_words[base + k] = frame_words[base + k];
          end
        end
      end
      default: push_byte(CMD_TRAIL_BYTE, 1'b1);
    endcase
  endfunction

  // drives one transaction and waits for it to be taken
  task automatic send_item(op_t op, logic [15:0] x, logic [15:0] y, logic on, bit predict);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_operation <= op;
    in_x_coord   <= x;
    in_y_coord   <= y;
    in_pixel_on  <= on;
    do @(posedge clk); while (in_full);
    if (predict) predict_panel_bytes(op, x, y, on);
    items_sent++;
  endtask

  task automatic send_frame();
    int          row0;
    int          npix;
    int          nflush;
    logic [15:0] x;
    logic [15:0] y;
    row0   = $urandom_range(0, PANEL_ROWS - 1);
    npix   = $urandom_range(1, 12);
    nflush = $urandom_range(1, 5);
    // a few frames are broken: missing start or end
    if ($urandom_range(0, 9) != 0)
      send_item(OP_START_FRAME, 16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
    repeat (npix) begin
      if ($urandom_range(0, 9) == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(0, PANEL_COLS - 1));
        y = 16'((row0 + $urandom_range(0, 3)) % PANEL_ROWS);
      end
      send_item(OP_SET_PIXEL, x, y, 1'($urandom), 1'b1);
    end
    for (int k = 0; k < nflush; k++) begin
      if ($urandom_range(0, 7) == 0) y = 16'($urandom);
      else y = 16'((row0 + k) % PANEL_ROWS);
      send_item(OP_FLUSH_ROW, 16'($urandom), y, 1'($urandom), 1'b1);
    end
    if ($urandom_range(0, 9) != 0)
      send_item(OP_END_FRAME, 16'($urandom), 16'($urandom), 1'($urandom), 1'b1);
  endtask

  initial begin
    in_push      <= 1'b0;
    in_operation <= OP_SET_PIXEL;
    in_x_coord   <= '0;
    in_y_coord   <= '0;
    in_pixel_on  <= 1'b0;
    rst_n        <= 1'b0;
    directed_rows = '{
      '{OP_START_FRAME, 16'h0000, 16'h0000, 1'b0, 1'b1, 1, CMD_WRITE_BYTE, 1'b1},
      // flushes that send nothing: row 0 equals the shadow after reset, rows 0xffff and 128 are out of range
      '{OP_FLUSH_ROW,   16'h0000, 16'h0000, 1'b0, 1'b1, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'h0000, 16'hffff, 1'b0, 1'b1, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'h0000, 16'd128,  1'b0, 1'b1, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd0,    16'd0,    1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd127,  16'd127,  1'b0, 1'b0, 0, 8'h00, 1'b0},
      // out of range pixels are dropped
      '{OP_SET_PIXEL,   16'd128,  16'd0,    1'b0, 1'b1, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd0,    16'd128,  1'b0, 1'b1, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'hffff, 16'hffff, 1'b0, 1'b1, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd31,   16'd0,    1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd32,   16'd0,    1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'hffff, 16'd0,    1'b1, 1'b0, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'h0000, 16'd0,    1'b0, 1'b1, 0, 8'h00, 1'b0},
      // toggle a pixel and restore it: row matches the shadow again
      '{OP_SET_PIXEL,   16'd0,    16'd0,    1'b1, 1'b0, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd0,    16'd0,    1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'h0000, 16'd0,    1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'h0000, 16'd127,  1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_END_FRAME,   16'habcd, 16'hffff, 1'b1, 1'b1, 1, CMD_TRAIL_BYTE, 1'b1},
      '{OP_START_FRAME, 16'hffff, 16'h1234, 1'b1, 1'b1, 1, CMD_WRITE_BYTE, 1'b1},
      '{OP_SET_PIXEL,   16'd127,  16'd127,  1'b1, 1'b0, 0, 8'h00, 1'b0},
      '{OP_SET_PIXEL,   16'd96,   16'd127,  1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_FLUSH_ROW,   16'h0000, 16'd127,  1'b0, 1'b0, 0, 8'h00, 1'b0},
      '{OP_END_FRAME,   16'h0000, 16'h0000, 1'b0, 1'b1, 1, CMD_TRAIL_BYTE, 1'b1}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // typed rows never change the panel state, so they skip the predictor
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed && directed_rows[i].typed_n > 0)
        push_byte(directed_rows[i].typed_byte, directed_rows[i].typed_last);
      send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].on, !directed_rows[i].typed);
    end

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          send_item(op_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    1'($urandom), 1'b1);
      end else begin
        send_frame();
      end
    end
    in_push <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) pop_burst = !pop_burst;
      gap = pop_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  // compare each popped transaction with the oldest expected byte
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %0h (last_byte %0b)", out_stream_byte, out_last_byte);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_stream_byte !== want.stream_byte) begin
          $error("stream_byte: expected %0h, got %0h", want.stream_byte, out_stream_byte);
          fail_count++;
        end
        if (out_last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, out_last_byte);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/mlcd_pkg.sv
design/mlcd_fifo.sv
design/mlcd_front.sv
design/mlcd_back.sv
design/memory_lcd_dirty_row_framebuffer_unit.sv
design/mlcd_checker.sv
sim/tb_top.sv
